// ----- hw/rtl/urta_pkg.sv -----
// shared widths, codes, character constants and digit helpers for the radix-to-ascii converter
package urta_pkg;

	localparam int unsigned ValueW   = 64;
	localparam int unsigned CharW    = 8;
	localparam int unsigned DigW     = 4;
	localparam int unsigned NumSlots = 22;
	localparam int unsigned DigRegW  = NumSlots * DigW;
	localparam int unsigned BcdDigits = 20;
	localparam int unsigned BcdW     = BcdDigits * DigW;
	localparam int unsigned OctPadW  = NumSlots * 3;
	localparam int unsigned CntW     = 5;
	localparam int unsigned IterW    = 7;
	localparam int unsigned PreW     = 2;

	// radix modes
	localparam logic [1:0] MODE_DEC    = 2'd0;
	localparam logic [1:0] MODE_OCT    = 2'd1;
	localparam logic [1:0] MODE_HEX_LO = 2'd2;
	localparam logic [1:0] MODE_HEX_UP = 2'd3;

	// size selector codes, the unused code acts as 32 bits
	localparam logic [1:0] SIZE_32 = 2'd0;
	localparam logic [1:0] SIZE_64 = 2'd1;
	localparam logic [1:0] SIZE_16 = 2'd2;

	localparam logic [IterW-1:0] ITER_16 = 7'd16;
	localparam logic [IterW-1:0] ITER_32 = 7'd32;
	localparam logic [IterW-1:0] ITER_64 = 7'd64;

	localparam logic [CntW-1:0] SLOT_COUNT = 5'(NumSlots);

	localparam logic [CharW-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CharW-1:0] CHAR_A_LO = 8'h61;
	localparam logic [CharW-1:0] CHAR_A_UP = 8'h41;
	localparam logic [CharW-1:0] CHAR_X_LO = 8'h78;
	localparam logic [CharW-1:0] CHAR_X_UP = 8'h58;

	// one digit value to its ascii character
	function automatic logic [CharW-1:0] digit_char(input logic [DigW-1:0] d, input logic upper);
		logic [CharW-1:0] base;
		if (d < 4'd10) begin
			digit_char = CHAR_ZERO + {4'b0, d};
		end else begin
			base = upper ? CHAR_A_UP : CHAR_A_LO;
			digit_char = base + {4'b0, d} - 8'd10;
		end
	endfunction

	// add three to every bcd digit of five or more
	function automatic logic [BcdW-1:0] bcd_adjust(input logic [BcdW-1:0] bcd);
		logic [BcdW-1:0] r;
		r = bcd;
		for (int i = 0; i < BcdDigits; i++) begin
			if (bcd[i*DigW +: DigW] >= 4'd5) begin
				r[i*DigW +: DigW] = bcd[i*DigW +: DigW] + 4'd3;
			end
		end
		return r;
	endfunction

	// spread octal digits into four-bit slots
	function automatic logic [DigRegW-1:0] oct_slots(input logic [ValueW-1:0] v);
		logic [OctPadW-1:0] w;
		logic [DigRegW-1:0] r;
		w = {2'b0, v};
		for (int i = 0; i < NumSlots; i++) begin
			r[i*DigW +: DigW] = {1'b0, w[i*3 +: 3]};
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/urta_if.sv -----
// valid/ready channel interfaces for numbers in and characters out
interface urta_num_if;
	logic                         valid;
	logic                         ready;
	logic [urta_pkg::ValueW-1:0]  value;
	logic [1:0]                   mode;
	logic [1:0]                   size_sel;
	logic                         alt_form;

	modport source (output valid, value, mode, size_sel, alt_form, input ready);
	modport sink   (input valid, value, mode, size_sel, alt_form, output ready);
endinterface

interface urta_text_if;
	logic                         valid;
	logic                         ready;
	logic [urta_pkg::CharW-1:0]   char_out;
	logic                         last;

	modport source (output valid, char_out, last, input ready);
	modport sink   (input valid, char_out, last, output ready);
endinterface

// ----- hw/rtl/unsigned_radix_to_ascii_top.sv -----
// unsigned number to ascii text converter, decimal, octal and hex
//
//  channel | dir | payload                             | transfer
//  --------+-----+-------------------------------------+----------------------------
//  num     | in  | value, mode, size_sel, alt_form     | num.valid && num.ready
//  text    | out | char_out, last                      | text.valid && text.ready
//
// one number at a time: num.ready is high only while the sequencer is idle
// decimal runs one shift-and-add-3 step per cycle over the 16, 32 or 64 kept bits,
// octal and hex load their digits directly
// then leading zero digits are dropped (up to 21), keeping at least one digit,
// then one character per cycle unless text stalls: prefix, then digits
// text stalls hold the sequencer in the prefix or digit phase, the output register
// lets the next number be taken while the final character still waits
// arst_n clears the sequencer and the output valid flag
module unsigned_radix_to_ascii_top (
	input logic         clk,
	input logic         arst_n,
	urta_num_if.sink    num,
	urta_text_if.source text
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_SKIP = 5'b00100,
		ST_PRE  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t state_q;

	// digit slots, slot 21 is the most significant and sits on top
	logic [urta_pkg::DigRegW-1:0] dig_q;
	// binary bits still to shift into the bcd slots, msb first
	logic [urta_pkg::ValueW-1:0]  bin_q;
	logic [urta_pkg::IterW-1:0]   iter_q;
	logic [urta_pkg::CntW-1:0]    cnt_q;
	logic [urta_pkg::PreW-1:0]    pre_q;
	logic                         upper_q;
	logic                         hex_q;

	logic                         out_valid_q;
	logic [urta_pkg::CharW-1:0]   char_q;
	logic                         last_q;

	logic [urta_pkg::ValueW-1:0]  kept;
	logic [urta_pkg::ValueW-1:0]  bin_load;
	logic [urta_pkg::IterW-1:0]   iter_load;
	logic [urta_pkg::PreW-1:0]    pre_load;
	logic [urta_pkg::BcdW-1:0]    bcd_adj;
	logic [urta_pkg::DigW-1:0]    top_dig;
	logic                         out_free;

	assign num.ready  = (state_q == ST_IDLE);
	assign text.valid = out_valid_q;
	assign text.char_out = char_q;
	assign text.last  = last_q;

	assign out_free = !out_valid_q || text.ready;
	assign top_dig  = dig_q[urta_pkg::DigRegW-1 -: urta_pkg::DigW];
	assign bcd_adj  = urta_pkg::bcd_adjust(dig_q[urta_pkg::BcdW-1:0]);

	// cut to the selected size, and line the kept bits up at the msb for the bcd shift
	always_comb begin
		unique case (num.size_sel)
			urta_pkg::SIZE_64: begin
				kept      = num.value;
				bin_load  = num.value;
				iter_load = urta_pkg::ITER_64;
			end
			urta_pkg::SIZE_16: begin
				kept      = {48'b0, num.value[15:0]};
				bin_load  = {num.value[15:0], 48'b0};
				iter_load = urta_pkg::ITER_16;
			end
			default: begin
				kept      = {32'b0, num.value[31:0]};
				bin_load  = {num.value[31:0], 32'b0};
				iter_load = urta_pkg::ITER_32;
			end
		endcase
	end

	// prefix looks at the raw value, before the cut
	always_comb begin
		pre_load = '0;
		if (num.alt_form && (num.value != '0)) begin
			unique case (num.mode)
				urta_pkg::MODE_OCT:    pre_load = 2'd1;
				urta_pkg::MODE_HEX_LO: pre_load = 2'd2;
				urta_pkg::MODE_HEX_UP: pre_load = 2'd2;
				default:               pre_load = 2'd0;
			endcase
		end
	end

	// output register holds a character until its transfer, refilled in prefix and digit phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == ST_PRE) || (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dig_q       <= '0;
			bin_q       <= '0;
			iter_q      <= '0;
			cnt_q       <= '0;
			pre_q       <= '0;
			upper_q     <= 1'b0;
			hex_q       <= 1'b0;
			char_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (num.valid) begin
						upper_q <= (num.mode == urta_pkg::MODE_HEX_UP);
						hex_q   <= num.mode[1];
						pre_q   <= pre_load;
						cnt_q   <= urta_pkg::SLOT_COUNT;
						iter_q  <= iter_load;
						bin_q   <= bin_load;
						unique case (num.mode)
							urta_pkg::MODE_DEC: begin
								dig_q   <= '0;
								state_q <= ST_CONV;
							end
							urta_pkg::MODE_OCT: begin
								dig_q   <= urta_pkg::oct_slots(kept);
								state_q <= ST_SKIP;
							end
							default: begin
								dig_q   <= {24'b0, kept};
								state_q <= ST_SKIP;
							end
						endcase
					end
				end
				ST_CONV: begin
					// one double-dabble step
					dig_q[urta_pkg::BcdW-1:0] <= {bcd_adj[urta_pkg::BcdW-2:0],
						bin_q[urta_pkg::ValueW-1]};
					bin_q  <= {bin_q[urta_pkg::ValueW-2:0], 1'b0};
					iter_q <= iter_q - 7'd1;
					if (iter_q == 7'd1) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					// drop leading zeros, keep at least one digit
					if ((top_dig == '0) && (cnt_q != 5'd1)) begin
						dig_q <= {dig_q[urta_pkg::DigRegW-urta_pkg::DigW-1:0], 4'b0};
						cnt_q <= cnt_q - 5'd1;
					end else if (pre_q != '0) begin
						state_q <= ST_PRE;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_PRE: begin
					if (out_free) begin
						last_q      <= 1'b0;
						if ((pre_q == 2'd1) && hex_q) begin
							char_q <= upper_q ? urta_pkg::CHAR_X_UP : urta_pkg::CHAR_X_LO;
						end else begin
							char_q <= urta_pkg::CHAR_ZERO;
						end
						pre_q <= pre_q - 2'd1;
						if (pre_q == 2'd1) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						char_q      <= urta_pkg::digit_char(top_dig, upper_q);
						last_q      <= (cnt_q == 5'd1);
						dig_q <= {dig_q[urta_pkg::DigRegW-urta_pkg::DigW-1:0], 4'b0};
						cnt_q <= cnt_q - 5'd1;
						if (cnt_q == 5'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/urta_checker.sv -----
// port-level checks for the radix-to-ascii converter and their bind
module urta_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       num_valid,
	input logic                       num_ready,
	input logic                       text_valid,
	input logic                       text_ready,
	input logic [urta_pkg::CharW-1:0] text_char,
	input logic                       text_last
);

	// a stalled character stays put
	a_text_hold: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_ready |=> text_valid && $stable(text_char) && $stable(text_last))
		else $error("stalled character changed");

	// busy after a number is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		num_valid && num_ready |=> !num_ready)
		else $error("ready right after a number transfer");

	// nothing appears while idle with no new number
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		num_ready && !num_valid && !text_valid |=> !text_valid)
		else $error("character with no number in work");

	// only digits and prefix letters come out
	a_charset: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid |-> ((text_char >= 8'h30) && (text_char <= 8'h39))
			|| ((text_char >= 8'h61) && (text_char <= 8'h66))
			|| ((text_char >= 8'h41) && (text_char <= 8'h46))
			|| (text_char == 8'h78) || (text_char == 8'h58))
		else $error("character outside the digit set");

endmodule

bind unsigned_radix_to_ascii_top urta_checker u_urta_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.num_valid  (num.valid),
	.num_ready  (num.ready),
	.text_valid (text.valid),
	.text_ready (text.ready),
	.text_char  (text.char_out),
	.text_last  (text.last)
);

// ----- test/tb_top.sv -----
// testbench for the radix-to-ascii converter, random and directed numbers checked per character
module tb_top;

	// idle cycles without any transfer before the run is declared hung;
	// the slowest steps are a 64-bit decimal conversion plus zero stripping and the
	// long receiver hold-off
	localparam int WatchdogLimit = 2000;
	localparam int LongHold      = 300;
	// numbers accepted before the receiver starts its long hold-off
	localparam int HoldAfter     = 60;
	// no idling on either side once this few numbers are left to send
	localparam int CalmTail      = 30;
	// quiet cycles at the end, covers one full decimal conversion
	localparam int SettleCycles  = 120;
	localparam int RandomItems   = 148;

	typedef struct {
		logic [urta_pkg::ValueW-1:0] value;
		logic [1:0]                  mode;
		logic [1:0]                  size_sel;
		logic                        alt_form;
		bit                          drain_first;
	} num_item_t;

	typedef struct {
		logic [urta_pkg::CharW-1:0] ch;
		logic                       last;
	} text_char_t;

	bit   clk = 1'b0;
	logic arst_n = 1'b0;

	urta_num_if  num_ch ();
	urta_text_if text_ch ();

	unsigned_radix_to_ascii_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_ch),
		.text   (text_ch)
	);

	num_item_t  pending_nums[$];
	text_char_t expected_text[$];

	// transfer flags sampled at the rising edge, read by the drivers at the falling edge
	bit num_fire;
	bit text_fire;
	int nums_accepted;
	int chars_seen;
	int fail_count;
	int stall_cycles;

	// sender and receiver idling state
	int tx_gap;
	int tx_rate;
	int rx_gap;
	int rx_rate;
	int rx_hold_left;
	bit long_hold_done;
	int rate_timer;

	text_char_t want;

	always #1 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [urta_pkg::CharW-1:0] exp_v,
			input logic [urta_pkg::CharW-1:0] got_v);
		$display("mismatch at character %0d: %s, expected %h got %h", chars_seen, what, exp_v,
			got_v);
		fail_count++;
	endtask

	// expected character string for one accepted number, most significant first
	function automatic void predict_text(input num_item_t it);
		logic [urta_pkg::ValueW-1:0] kept;
		logic [urta_pkg::DigW-1:0]   dig;
		logic [urta_pkg::CharW-1:0]  digits[$];
		text_char_t                  entry;
		// the unused size code falls into the 32-bit cut
		case (it.size_sel)
			urta_pkg::SIZE_64: kept = it.value;
			urta_pkg::SIZE_16: kept = {48'b0, it.value[15:0]};
			default: kept = {32'b0, it.value[31:0]};
		endcase
		if (kept == '0) begin
			digits.push_front(urta_pkg::CHAR_ZERO);
		end
		while (kept != '0) begin
			case (it.mode)
				urta_pkg::MODE_DEC: begin
					dig = urta_pkg::DigW'(kept % 10);
					kept = kept / 10;
				end
				urta_pkg::MODE_OCT: begin
					dig = {1'b0, kept[2:0]};
					kept = kept >> 3;
				end
				default: begin
					dig = kept[3:0];
					kept = kept >> 4;
				end
			endcase
			if (dig < 4'd10) begin
				digits.push_front(urta_pkg::CHAR_ZERO + urta_pkg::CharW'(dig));
			end else if (it.mode == urta_pkg::MODE_HEX_UP) begin
				digits.push_front(urta_pkg::CHAR_A_UP + urta_pkg::CharW'(dig) - 8'd10);
			end else begin
				digits.push_front(urta_pkg::CHAR_A_LO + urta_pkg::CharW'(dig) - 8'd10);
			end
		end
		// prefix looks at the value as given, so a value cut down to zero still gets one
		if (it.alt_form && it.value != '0) begin
			if (it.mode == urta_pkg::MODE_OCT) begin
				digits.push_front(urta_pkg::CHAR_ZERO);
			end else if (it.mode != urta_pkg::MODE_DEC) begin
				digits.push_front(it.mode == urta_pkg::MODE_HEX_UP ? urta_pkg::CHAR_X_UP
					: urta_pkg::CHAR_X_LO);
				digits.push_front(urta_pkg::CHAR_ZERO);
			end
		end
		foreach (digits[i]) begin
			entry.ch = digits[i];
			entry.last = (i == digits.size() - 1);
			expected_text.push_back(entry);
		end
	endfunction

	task automatic queue_num(input logic [urta_pkg::ValueW-1:0] value, input logic [1:0] mode,
			input logic [1:0] size_sel, input logic alt_form, input bit drain_first);
		num_item_t it;
		it.value = value;
		it.mode = mode;
		it.size_sel = size_sel;
		it.alt_form = alt_form;
		it.drain_first = drain_first;
		pending_nums.push_back(it);
	endtask

	// values spread over sizes, small numbers, single bits and values whose kept bits are zero
	function automatic logic [urta_pkg::ValueW-1:0] random_value();
		logic [urta_pkg::ValueW-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 6))
			0: v = {32'b0, v[31:0]};
			1: v = {48'b0, v[15:0]};
			2: v = urta_pkg::ValueW'($urandom_range(0, 20));
			3: v = 64'd1 << $urandom_range(0, 63);
			4: v = v & ~64'hFFFF_FFFF;
			5: v = v & ~64'hFFFF;
			default: ;
		endcase
		return v;
	endfunction

	// monitor: sample both channels, predict on number transfers, check character transfers
	always @(posedge clk) begin
		num_fire = arst_n && num_ch.valid && num_ch.ready;
		text_fire = arst_n && text_ch.valid && text_ch.ready;
		if (num_fire) begin
			predict_text('{num_ch.value, num_ch.mode, num_ch.size_sel, num_ch.alt_form, 1'b0});
			nums_accepted++;
		end
		if (text_fire) begin
			if (expected_text.size() == 0) begin
				report_mismatch("character with nothing expected", '0, text_ch.char_out);
			end else begin
				want = expected_text.pop_front();
				if (text_ch.char_out !== want.ch) begin
					report_mismatch("char_out", want.ch, text_ch.char_out);
				end
				if (text_ch.last !== want.last) begin
					report_mismatch("last", urta_pkg::CharW'(want.last),
						urta_pkg::CharW'(text_ch.last));
				end
			end
			chars_seen++;
		end
		// watchdog: only cycles without any transfer count toward the limit
		if (!arst_n || num_fire || text_fire) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= WatchdogLimit) begin
			$display("watchdog: no transfer for %0d cycles", stall_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// sender: a presented number stays until its transfer, gaps only fall between numbers
	always @(negedge clk) begin
		rate_timer++;
		if (rate_timer % 64 == 0) begin
			tx_rate = $urandom_range(0, 3);
			rx_rate = $urandom_range(0, 3);
		end
		if (!arst_n) begin
			num_ch.valid <= 1'b0;
		end else if (num_fire || !num_ch.valid) begin
			if (tx_gap > 0) begin
				tx_gap--;
				num_ch.valid <= 1'b0;
			end else if (pending_nums.size() == 0) begin
				num_ch.valid <= 1'b0;
			end else if (pending_nums[0].drain_first && expected_text.size() != 0) begin
				// pause until every character of earlier numbers has come out
				num_ch.valid <= 1'b0;
			end else if (pending_nums.size() > CalmTail && tx_rate != 0
					&& $urandom_range(0, 7) < tx_rate) begin
				tx_gap = $urandom_range(1, 18) - 1;
				num_ch.valid <= 1'b0;
			end else begin
				num_ch.value <= pending_nums[0].value;
				num_ch.mode <= pending_nums[0].mode;
				num_ch.size_sel <= pending_nums[0].size_sel;
				num_ch.alt_form <= pending_nums[0].alt_form;
				num_ch.valid <= 1'b1;
				void'(pending_nums.pop_front());
			end
		end
	end

	// receiver: random stall bursts, plus one long hold-off so the converter backs up
	always @(negedge clk) begin
		if (!arst_n) begin
			text_ch.ready <= 1'b0;
		end else if (rx_hold_left > 0) begin
			rx_hold_left--;
			text_ch.ready <= 1'b0;
		end else if (!long_hold_done && nums_accepted >= HoldAfter) begin
			// the sender keeps offering numbers meanwhile, so num.ready has to drop
			long_hold_done = 1'b1;
			rx_hold_left = LongHold - 1;
			text_ch.ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			text_ch.ready <= 1'b0;
		end else if (pending_nums.size() > CalmTail && rx_rate != 0
				&& $urandom_range(0, 7) < rx_rate) begin
			rx_gap = $urandom_range(1, 18) - 1;
			text_ch.ready <= 1'b0;
		end else begin
			text_ch.ready <= 1'b1;
		end
	end

	initial begin
		int total;
		num_ch.valid = 1'b0;
		num_ch.value = '0;
		num_ch.mode = urta_pkg::MODE_DEC;
		num_ch.size_sel = urta_pkg::SIZE_32;
		num_ch.alt_form = 1'b0;
		text_ch.ready = 1'b0;
		tx_rate = 1;
		rx_rate = 1;

		// directed part
		// zero gives a single digit and never a prefix
		queue_num(64'd0, urta_pkg::MODE_DEC, urta_pkg::SIZE_64, 1'b1, 1'b0);
		queue_num(64'd0, urta_pkg::MODE_HEX_LO, urta_pkg::SIZE_64, 1'b1, 1'b0);
		// all ones in every mode, octal with prefix gives the longest text
		queue_num('1, urta_pkg::MODE_DEC, urta_pkg::SIZE_64, 1'b1, 1'b0);
		queue_num('1, urta_pkg::MODE_OCT, urta_pkg::SIZE_64, 1'b1, 1'b0);
		queue_num('1, urta_pkg::MODE_HEX_LO, urta_pkg::SIZE_64, 1'b1, 1'b0);
		queue_num('1, urta_pkg::MODE_HEX_UP, urta_pkg::SIZE_64, 1'b1, 1'b0);
		queue_num('1, urta_pkg::MODE_DEC, urta_pkg::SIZE_32, 1'b0, 1'b0);
		queue_num('1, urta_pkg::MODE_HEX_LO, urta_pkg::SIZE_16, 1'b0, 1'b0);
		queue_num('1, urta_pkg::MODE_OCT, urta_pkg::SIZE_16, 1'b1, 1'b0);
		// unused size code behaves as the 32-bit cut
		queue_num(64'h1_2345_6789, urta_pkg::MODE_HEX_UP, 2'd3, 1'b1, 1'b0);
		queue_num('1, urta_pkg::MODE_DEC, 2'd3, 1'b0, 1'b0);
		// nonzero value cut down to zero still gets its prefix, decimal has none
		queue_num(64'h1_0000_0000, urta_pkg::MODE_OCT, urta_pkg::SIZE_32, 1'b1, 1'b0);
		queue_num(64'h1_0000_0000, urta_pkg::MODE_HEX_LO, urta_pkg::SIZE_32, 1'b1, 1'b0);
		queue_num(64'h1_0000, urta_pkg::MODE_HEX_UP, urta_pkg::SIZE_16, 1'b1, 1'b0);
		queue_num(64'h1_0000, urta_pkg::MODE_DEC, urta_pkg::SIZE_16, 1'b1, 1'b0);
		// alternate form does nothing in decimal
		queue_num(64'd12345, urta_pkg::MODE_DEC, urta_pkg::SIZE_32, 1'b1, 1'b0);
		// top bit alone, lowest bit alone, the two checkerboards, then nine and ten
		queue_num(64'h8000_0000_0000_0000, urta_pkg::MODE_DEC, urta_pkg::SIZE_64, 1'b0, 1'b0);
		queue_num(64'd1, urta_pkg::MODE_OCT, urta_pkg::SIZE_64, 1'b1, 1'b0);
		queue_num(64'hAAAA_AAAA_AAAA_AAAA, urta_pkg::MODE_HEX_LO, urta_pkg::SIZE_64, 1'b0, 1'b0);
		queue_num(64'h5555_5555_5555_5555, urta_pkg::MODE_HEX_UP, urta_pkg::SIZE_64, 1'b1, 1'b0);
		queue_num(64'd9, urta_pkg::MODE_DEC, urta_pkg::SIZE_64, 1'b0, 1'b0);
		queue_num(64'd10, urta_pkg::MODE_DEC, urta_pkg::SIZE_16, 1'b0, 1'b0);

		// random part, with one drain pause at the start and one in the middle
		for (int i = 0; i < RandomItems; i++) begin
			queue_num(random_value(), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
				1'($urandom_range(0, 1)), i == 0 || i == RandomItems / 2);
		end
		total = pending_nums.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (nums_accepted < total) @(posedge clk);
		while (expected_text.size() != 0) @(posedge clk);
		// anything the converter still sends now has no expectation and fails the check
		repeat (SettleCycles) @(posedge clk);

		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
